// ===== rtl/dirty_mask_delta_packer_macros.svh =====
// ---------------------------------------------------------------------------
// Dirty-mask delta packer assertion macros
// Shared property shorthands, clocked on clk_i, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef DIRTY_MASK_DELTA_PACKER_MACROS_SVH
`define DIRTY_MASK_DELTA_PACKER_MACROS_SVH

// Same-cycle implication.
`define DMDP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dmdp assertion failed");

// Next-cycle implication.
`define DMDP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dmdp assertion failed");

`endif

// ===== rtl/dmdp_pkg.sv =====
// ---------------------------------------------------------------------------
// Dirty-mask delta packer package
// Sizes, result kind codes, payload structs and control/status bundles.
// ---------------------------------------------------------------------------
package dmdp_pkg;

  localparam int GROUPS    = 5;
  localparam int SLOTS     = 32;
  localparam int WORD_W    = 32;
  localparam int GROUP_W   = 3;
  localparam int SLOT_W    = 5;
  localparam int CNT_W     = 6;
  localparam int CFG_IDX_W = 3;
  localparam int DEPTH     = GROUPS * SLOTS;
  localparam int ADDR_W    = $clog2(DEPTH);

  localparam logic [CNT_W-1:0] CFG_RESET = 6'd32;

  localparam logic OP_MARK = 1'b0;
  localparam logic OP_DUMP = 1'b1;

  localparam logic [1:0] KIND_MASK  = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_NONE  = 2'd2;

  typedef struct packed {
    logic                op;
    logic [GROUP_W-1:0]  group;
    logic [SLOT_W-1:0]   slot;
    logic [WORD_W-1:0]   new_value;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [1:0]        kind;
    logic              last;
  } out_item_t;

  // Controller -> datapath
  typedef struct packed {
    logic mark_we;
    logic dump_latch;
    logic head_emit;
    logic scan_adv;
    logic rd_issue;
    logic val_emit;
  } dmdp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic group_ok;
    logic slot_ok;
    logic op_dump;
    logic mask_zero;
    logic rem_zero;
    logic bit_hit;
    logic last;
    logic out_free;
  } dmdp_sts_t;

endpackage

// ===== rtl/dmdp_datapath.sv =====
// ---------------------------------------------------------------------------
// Dirty-mask delta packer datapath
// Value memory, changed masks, count registers, scan state, output register.
// ---------------------------------------------------------------------------
`include "dirty_mask_delta_packer_macros.svh"

module dmdp_datapath import dmdp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  in_item_t             in_data_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CNT_W-1:0]     cfg_data_i,
  input  dmdp_cmd_t            cmd_i,
  output dmdp_sts_t            sts_o,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output out_item_t            out_data_o
);

  logic [WORD_W-1:0]  mem [DEPTH];
  logic [WORD_W-1:0]  mask_q [GROUPS];
  logic [CNT_W-1:0]   cfg_q [GROUPS];
  logic [GROUP_W-1:0] grp_q;
  logic [WORD_W-1:0]  rem_q;
  logic [SLOT_W-1:0]  idx_q;
  logic               last_q;
  logic [WORD_W-1:0]  rdata_q;
  out_item_t          out_q;
  logic               out_valid_q;

  logic [WORD_W-1:0] mask_sel;
  logic [CNT_W-1:0]  cnt_sat;
  logic [WORD_W-1:0] cnt_mask;
  logic [WORD_W-1:0] head_rem;
  logic [WORD_W-1:0] rem_clr;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic              out_free;

  always_comb begin
    mask_sel = mask_q[grp_q];
    cnt_sat  = (cfg_q[grp_q] > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : cfg_q[grp_q];
    for (int i = 0; i < WORD_W; i++) begin
      cnt_mask[i] = (CNT_W'(i) < cnt_sat);
    end
    head_rem = mask_sel & cnt_mask;
    rem_clr  = rem_q & ~(WORD_W'(1) << idx_q);
  end

  assign wr_addr  = ADDR_W'(ADDR_W'(in_data_i.group) * ADDR_W'(SLOTS))
                  + ADDR_W'(in_data_i.slot);
  assign rd_addr  = ADDR_W'(ADDR_W'(grp_q) * ADDR_W'(SLOTS)) + ADDR_W'(idx_q);
  assign out_free = !out_valid_q || !out_stall_i;

  assign sts_o.group_ok  = ({1'b0, in_data_i.group} < (GROUP_W + 1)'(GROUPS));
  assign sts_o.slot_ok   = ({1'b0, in_data_i.slot} < (SLOT_W + 1)'(SLOTS));
  assign sts_o.op_dump   = (in_data_i.op == OP_DUMP);
  assign sts_o.mask_zero = (mask_sel == '0);
  assign sts_o.rem_zero  = (head_rem == '0);
  assign sts_o.bit_hit   = rem_q[idx_q];
  assign sts_o.last      = last_q;
  assign sts_o.out_free  = out_free;

  // value store: one write port (mark), one registered read port (scan)
  always_ff @(posedge clk_i) begin
    if (cmd_i.mark_we) begin
      mem[wr_addr] <= in_data_i.new_value;
    end
    if (cmd_i.rd_issue) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < GROUPS; g++) begin
        mask_q[g] <= '0;
        cfg_q[g]  <= CFG_RESET;
      end
    end else begin
      if (cfg_we_i && ({1'b0, cfg_idx_i} < (CFG_IDX_W + 1)'(GROUPS))) begin
        cfg_q[cfg_idx_i] <= cfg_data_i;
      end
      if (cmd_i.mark_we) begin
        mask_q[in_data_i.group] <= mask_q[in_data_i.group]
                                 | (WORD_W'(1) << in_data_i.slot);
      end
      if (cmd_i.head_emit && !sts_o.mask_zero) begin
        mask_q[grp_q] <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_q  <= '0;
      rem_q  <= '0;
      idx_q  <= '0;
      last_q <= 1'b0;
    end else begin
      if (cmd_i.dump_latch) begin
        grp_q <= in_data_i.group;
      end
      if (cmd_i.head_emit) begin
        rem_q <= head_rem;
        idx_q <= '0;
      end
      if (cmd_i.scan_adv) begin
        idx_q <= idx_q + SLOT_W'(1);
      end
      if (cmd_i.rd_issue) begin
        rem_q  <= rem_clr;
        last_q <= (rem_clr == '0);
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.head_emit || cmd_i.val_emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.head_emit) begin
      if (sts_o.mask_zero) begin
        out_q <= '{word: '0, kind: KIND_NONE, last: 1'b1};
      end else begin
        out_q <= '{word: mask_sel, kind: KIND_MASK, last: sts_o.rem_zero};
      end
    end else if (cmd_i.val_emit) begin
      out_q <= '{word: rdata_q, kind: KIND_VALUE, last: last_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a dump clears the group's mask once its head word goes out
  `DMDP_ASSERT_NEXT(a_mask_cleared, cmd_i.head_emit && !sts_o.mask_zero, mask_q[grp_q] == '0)
  // a value read is only issued for a pending bit
  `DMDP_ASSERT_IMPL(a_read_hits, cmd_i.rd_issue, rem_q[idx_q])
  // no emit overwrites a result still held by a stall
  `DMDP_ASSERT_IMPL(a_emit_free, cmd_i.head_emit || cmd_i.val_emit, out_free)

endmodule

// ===== rtl/dmdp_ctrl.sv =====
// ---------------------------------------------------------------------------
// Dirty-mask delta packer controller
// Accepts marks and dumps, sequences the head word, slot scan and value words.
// ---------------------------------------------------------------------------
`include "dirty_mask_delta_packer_macros.svh"

module dmdp_ctrl import dmdp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  dmdp_sts_t sts_i,
  output dmdp_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_HEAD = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && sts_i.group_ok) begin
          if (sts_i.op_dump) begin
            cmd_o.dump_latch = 1'b1;
            state_d          = ST_HEAD;
          end else if (sts_i.slot_ok) begin
            cmd_o.mark_we = 1'b1;
          end
        end
      end
      ST_HEAD: begin
        if (sts_i.out_free) begin
          cmd_o.head_emit = 1'b1;
          state_d = (sts_i.mask_zero || sts_i.rem_zero) ? ST_IDLE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_adv = 1'b1;
        if (sts_i.bit_hit) begin
          cmd_o.rd_issue = 1'b1;
          state_d        = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.val_emit = 1'b1;
          state_d        = sts_i.last ? ST_IDLE : ST_SCAN;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // value words only follow a memory read
  `DMDP_ASSERT_IMPL(a_emit_after_read, state_q == ST_EMIT,
                    $past(state_q) == ST_SCAN || $past(state_q) == ST_EMIT)
  // the head word is only reached from an accepted dump
  `DMDP_ASSERT_IMPL(a_head_after_idle, state_q == ST_HEAD,
                    $past(state_q) == ST_IDLE || $past(state_q) == ST_HEAD)

endmodule

// ===== rtl/dirty_mask_delta_packer.sv =====
// ---------------------------------------------------------------------------
// Dirty-mask delta packer
// Five groups of 32 words with changed masks; a dump emits the mask and the
// changed values below the group's variable count, then clears the mask.
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------------
//  in      | to block  | in_valid_i / in_stall_o | in_item_t  (op group slot val)
//  out     | from block| out_valid_o/out_stall_i | out_item_t (word kind last)
//  cfg     | to block  | cfg_we_i                | cfg_idx_i, cfg_data_i
//
//  A mark is taken as soon as it is offered and the next transaction can follow at once.
//  A dump is accepted, then the head word goes out, then the slots are
//  scanned up to the last pending one, with a value word for each pending
//  slot (the value memory has a single registered read port).
//  Reset (rst_ni, async low) clears masks and sets counts to 32; the value
//  memory is not cleared, no clearing pass is needed.
//  A stall on the out channel holds the sequencer at the next word to emit;
//  the slot scan runs on to the next pending slot and waits there. The input
//  stalls while a dump is in progress.
// ---------------------------------------------------------------------------
module dirty_mask_delta_packer import dmdp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input transaction channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_data_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CNT_W-1:0]     cfg_data_i
);

  dmdp_cmd_t cmd;
  dmdp_sts_t sts;

  // sequencer: accepts only in its idle state
  dmdp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // storage, scan state and the output register
  dmdp_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== tb/sv/tb_dirty_mask_delta_packer.sv =====
// ---------------------------------------------------------------------------
// Dirty-mask delta packer testbench
// Marks and dumps go in over a valid/stall channel; a shadow copy of the
// value store, changed masks and variable counts predicts every result
// word, which a scoreboard compares field by field as results drain out.
// ---------------------------------------------------------------------------
import dmdp_pkg::*;

class packer_scoreboard;
  logic [WORD_W-1:0] shadow_words [GROUPS][SLOTS];
  logic [SLOTS-1:0]  shadow_masks [GROUPS];
  logic [CNT_W-1:0]  var_counts   [GROUPS];
  out_item_t         expected_q   [$];
  int                mismatches;

  function new();
    mismatches = 0;
    foreach (shadow_masks[g]) begin
      shadow_masks[g] = '0;
      var_counts[g]   = CFG_RESET;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void set_count(int idx, logic [CNT_W-1:0] cnt);
    if (idx < GROUPS) var_counts[idx] = cnt;
  endfunction

  function void queue_result(logic [WORD_W-1:0] word, logic [1:0] kind, logic last);
    out_item_t r;
    r.word = word;
    r.kind = kind;
    r.last = last;
    expected_q.insert(expected_q.size(), r);
  endfunction

  // Mask word first, then one value per set bit below the variable count; an empty mask gives a lone none word.
  function void expand_dump(int g);
    int               limit;
    int               follow;
    logic [SLOTS-1:0] mask;
    mask = shadow_masks[g];
    if (mask == '0) begin
      queue_result('0, KIND_NONE, 1'b1);
      return;
    end
    limit  = (var_counts[g] > SLOTS) ? SLOTS : int'(var_counts[g]);
    follow = 0;
    for (int i = 0; i < limit; i++) if (mask[i]) follow++;
    queue_result(WORD_W'(mask), KIND_MASK, follow == 0);
    for (int i = 0; i < limit; i++) begin
      if (mask[i]) begin
        follow--;
        queue_result(shadow_words[g][i], KIND_VALUE, follow == 0);
      end
    end
    shadow_masks[g] = '0;
  endfunction

  function void note_accepted(in_item_t it);
    if (it.group >= GROUPS) return;
    if (it.op == OP_MARK) begin
      // slot is 5 bits wide, so it always lands inside the group
      shadow_words[it.group][it.slot] = it.new_value;
      shadow_masks[it.group][it.slot] = 1'b1;
    end else begin
      expand_dump(it.group);
    end
  endfunction

  // Lines stop after the first hundred; the count keeps going.
  task report(string what);
    if (mismatches < 100) $display("MISMATCH: %s", what);
    mismatches++;
  endtask

  task check_result(out_item_t got);
    out_item_t want;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected result word=%h kind=%0d last=%0d",
                       got.word, got.kind, got.last));
      return;
    end
    want = expected_q.pop_front();
    if (got.word !== want.word)
      report($sformatf("word %h, expected %h", got.word, want.word));
    if (got.kind !== want.kind)
      report($sformatf("kind %0d, expected %0d (word %h)", got.kind, want.kind, want.word));
    if (got.last !== want.last)
      report($sformatf("last %0d, expected %0d (word %h)", got.last, want.last, want.word));
  endtask
endclass

module tb_dirty_mask_delta_packer;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_item_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_item_t            out_data_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [CNT_W-1:0]     cfg_data_i  = '0;

  packer_scoreboard board = new();

  // Per-phase idle limits for the sender and the receiver; 0 = no idling.
  int in_gap_max   = 0;
  int out_gap_max  = 0;
  int marks_sent   = 0;
  int dumps_sent   = 0;
  int ignored_sent = 0;
  int results_seen = 0;
  int cfg_writes   = 0;

  always #5 clk_i = ~clk_i;

  dirty_mask_delta_packer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Idle draw: a third of the time no wait at all, else up to the limit.
  function automatic int draw_wait(int max_wait);
    if (max_wait == 0) return 0;
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, max_wait);
  endfunction

  function automatic in_item_t make_item(logic op, int g, int s, logic [WORD_W-1:0] v);
    in_item_t it;
    it.op        = op;
    it.group     = GROUP_W'(g);
    it.slot      = SLOT_W'(s);
    it.new_value = v;
    return it;
  endfunction

  // Mostly random words, with the all-zero and all-one extremes mixed in.
  function automatic logic [WORD_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // One input transaction. valid is set by NBA at a rising edge and the
  // transaction is taken at the first later edge where stall is low. The
  // caller either sends the next item or lowers valid in that same step.
  task automatic send_item(input in_item_t it);
    int gap;
    gap = draw_wait(in_gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_accepted(it);
    if (it.group >= GROUPS)    ignored_sent++;
    else if (it.op == OP_MARK) marks_sent++;
    else                       dumps_sent++;
  endtask

  // Drop valid, wait until every predicted word has come out, then give
  // an ignored item or a trailing mark time to retire.
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Writes all five counts back to back; optionally also an index past the
  // register list, which must leave every count alone.
  task automatic program_counts(input logic [CNT_W-1:0] cnt [GROUPS], input bit poke_unused);
    for (int i = 0; i < GROUPS; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CFG_IDX_W'(i);
      cfg_data_i <= cnt[i];
      @(posedge clk_i);
      board.set_count(i, cnt[i]);
      cfg_writes++;
    end
    if (poke_unused) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CFG_IDX_W'($urandom_range(GROUPS, 7));
      cfg_data_i <= CNT_W'($urandom());
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Random phase: mostly well-formed mark bursts closed by a dump of the
  // same group; the rest is traffic to absent groups and lone dumps.
  task automatic random_phase(input int budget);
    int done;
    int choice;
    int g;
    int marks;
    done = 0;
    while (done < budget) begin
      choice = $urandom_range(0, 9);
      if (choice < 7) begin
        g = $urandom_range(0, GROUPS - 1);
        case ($urandom_range(0, 9))
          0: begin
            // sweep every slot: full mask, 32 values
            for (int s = 0; s < SLOTS; s++)
              send_item(make_item(OP_MARK, g, s, pick_value()));
            marks = SLOTS;
          end
          1: begin
            marks = $urandom_range(12, 40);
            repeat (marks)
              send_item(make_item(OP_MARK, g, $urandom_range(0, SLOTS - 1), pick_value()));
          end
          default: begin
            marks = $urandom_range(1, 6);
            repeat (marks)
              send_item(make_item(OP_MARK, g, $urandom_range(0, SLOTS - 1), pick_value()));
          end
        endcase
        send_item(make_item(OP_DUMP, g, $urandom_range(0, SLOTS - 1), $urandom()));
        done += marks + 1;
      end else if (choice < 9) begin
        // group 5..7: dropped by the block, not counted
        send_item(make_item(1'($urandom_range(0, 1)), $urandom_range(GROUPS, 7),
                            $urandom_range(0, SLOTS - 1), $urandom()));
      end else begin
        // lone dump, often of a group with nothing pending
        send_item(make_item(OP_DUMP, $urandom_range(0, GROUPS - 1),
                            $urandom_range(0, SLOTS - 1), $urandom()));
        done++;
      end
    end
  endtask

  // Result sink: random stall before each transaction, check on accept.
  initial begin : result_sink
    int hold;
    wait (rst_ni === 1'b1);
    forever begin
      hold = draw_wait(out_gap_max);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      board.check_result(out_data_o);
      results_seen++;
    end
  end

  initial begin : stimulus
    logic [CNT_W-1:0] cnt [GROUPS];
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset counts (32 everywhere); sender busy, receiver idles.
    in_gap_max  = 0;
    out_gap_max = 18;
    send_item(make_item(OP_DUMP, 0, 0, '0));           // empty group: none word only
    send_item(make_item(OP_MARK, 0, 0, '0));
    send_item(make_item(OP_MARK, 0, SLOTS - 1, '1));
    send_item(make_item(OP_DUMP, 0, 0, '0));           // both ends of the mask
    send_item(make_item(OP_DUMP, 0, 0, '0));           // cleared by the dump
    send_item(make_item(OP_MARK, GROUPS, 1, '1));      // absent groups
    send_item(make_item(OP_MARK, 7, 2, 32'h1234_5678));
    send_item(make_item(OP_DUMP, 7, 0, '0));
    send_item(make_item(OP_DUMP, 6, 0, '0));
    send_item(make_item(OP_MARK, 4, 5, 32'hA5A5_A5A5));
    send_item(make_item(OP_MARK, 4, 5, 32'h5A5A_5A5A)); // overwrite same slot
    send_item(make_item(OP_DUMP, 4, 31, '1));
    settle_block();

    // Directed, odd counts: zero, saturating 63, one, 31, full.
    cnt = '{6'd0, 6'd63, 6'd1, 6'd31, 6'd32};
    program_counts(cnt, 1'b1);
    in_gap_max  = 18;
    out_gap_max = 0;
    send_item(make_item(OP_MARK, 0, 3, 32'h0000_0001));
    send_item(make_item(OP_DUMP, 0, 0, '0));           // mask alone, last set
    send_item(make_item(OP_MARK, 1, SLOTS - 1, 32'h8000_0000));
    send_item(make_item(OP_DUMP, 1, 0, '0));
    send_item(make_item(OP_MARK, 2, 0, 32'hFFFF_0000));
    send_item(make_item(OP_MARK, 2, 1, 32'h0000_FFFF));
    send_item(make_item(OP_DUMP, 2, 0, '0));           // bit 1 masked, no value
    send_item(make_item(OP_MARK, 3, SLOTS - 1, 32'hCAFE_0001));
    send_item(make_item(OP_MARK, 3, 30, 32'hCAFE_0002));
    send_item(make_item(OP_DUMP, 3, 0, '0));           // bit 31 beyond count
    send_item(make_item(OP_MARK, 4, 17, $urandom()));
    send_item(make_item(OP_DUMP, 4, 0, '0));
    settle_block();

    // Random phases, each with fresh counts and its own idle profile.
    for (int p = 0; p < 8; p++) begin
      foreach (cnt[g]) begin
        case ($urandom_range(0, 5))
          0:       cnt[g] = 6'd0;
          1:       cnt[g] = 6'd32;
          2:       cnt[g] = 6'd63;
          default: cnt[g] = CNT_W'($urandom_range(0, 63));
        endcase
      end
      program_counts(cnt, 1'($urandom_range(0, 1)));
      if (p == 0) begin
        in_gap_max  = 0;
        out_gap_max = 0;
      end else begin
        in_gap_max  = ($urandom_range(0, 2) == 0) ? 0 : (($urandom_range(0, 1) != 0) ? 4 : 18);
        out_gap_max = ($urandom_range(0, 2) == 0) ? 0 : (($urandom_range(0, 1) != 0) ? 4 : 18);
      end
      random_phase(28);
      settle_block();
    end

    $display("covered %0d marks, %0d dumps and %0d dropped transactions; %0d results checked",
             marks_sent, dumps_sent, ignored_sent, results_seen);
    $display("variable counts written %0d times, zero, full and saturating values included",
             cfg_writes);
    if (board.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #10_000_000;
    $display("timeout with %0d results still expected", board.pending());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
